### design/tss_pkg.sv
`timescale 1ns / 1ps
package tss_pkg;

  typedef enum logic [2:0] {
    FN_CREATE  = 3'd0,
    FN_TICK    = 3'd1,
    FN_YIELD   = 3'd2,
    FN_BLOCK   = 3'd3,
    FN_UNBLOCK = 3'd4,
    FN_SLEEP   = 3'd5,
    FN_WAKEUP  = 3'd6,
    FN_RELEASE = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_WAITING  = 3'd4,
    ST_SLEEPING = 3'd5
  } tstate_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_NO_READY = 2'd2,
    STS_BAD_SLOT = 2'd3
  } status_e;

  localparam logic CFG_MS_PER_TICK = 1'b0;
  localparam logic CFG_IDLE_SLOT   = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  slot;
    logic [31:0] value;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [5:0] running;
    logic       switched;
    logic [5:0] created;
    logic [1:0] status;
  } out_t;

  // classified request passed from front to back
  typedef struct packed {
    func_e       op;
    logic [5:0]  slot;
    logic        slot_in_range;
    logic        value_zero;
    logic [31:0] value;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [9:0] ms_per_tick;
    logic [5:0] idle_slot;
  } cfg_t;

endpackage

### design/time_slice_task_scheduler.sv
`timescale 1ns / 1ps
// Reschedule and wakeup scan the task table one slot per cycle; sleep first runs a restoring
// divide of the request value by ms_per_tick, then stores the wake time.
// One request in flight in the back end, so it starts no new request until the last result
// is taken into the output register; a 2-deep queue keeps accepting meanwhile.
// Reset (async, active low) frees all slots, running slot 0, ms_per_tick 10, idle slot 0.
module time_slice_task_scheduler
  import tss_pkg::*;
#(
  parameter int TASK_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_rsp_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [9:0] cfg_data_i
);

  cfg_t cfg_q;
  logic q_valid, q_pop;
  req_t q_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ms_per_tick <= 10'd10;
      cfg_q.idle_slot   <= 6'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MS_PER_TICK) cfg_q.ms_per_tick <= cfg_data_i;
      if (cfg_idx_i == CFG_IDLE_SLOT) cfg_q.idle_slot <= cfg_data_i[5:0];
    end
  end

  tss_front #(.TASK_SLOTS(TASK_SLOTS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_req_o    (q_req)
  );

  tss_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_req_i     (q_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

### design/tss_front.sv
`timescale 1ns / 1ps
module tss_front
  import tss_pkg::*;
#(
  parameter int TASK_SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output req_t q_req_o
);

  req_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  req_t       cls;
  logic       push, pop;

  always_comb begin
    cls.op            = func_e'(in_req_i.func);
    cls.slot          = in_req_i.slot;
    cls.slot_in_range = (32'(in_req_i.slot) < TASK_SLOTS);
    cls.value_zero    = (in_req_i.value == 32'd0);
    cls.value         = in_req_i.value;
    cls.now           = in_req_i.now;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_req_o    = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/tss_back.sv
`timescale 1ns / 1ps
module tss_back
  import tss_pkg::*;
#(
  parameter int TASK_SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_valid_i,
  output logic q_pop_o,
  input  req_t q_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_rsp_o
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [SW:0] N_CNT = (SW + 1)'(TASK_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CREATE, S_TICK, S_DIV, S_SLEEP, S_RESCHED, S_WAKE, S_DONE
  } state_e;

  state_e        state_q;
  logic          used_q [TASK_SLOTS];
  tstate_e       st_q   [TASK_SLOTS];
  logic [SW-1:0] run_q;

  logic [31:0]   mem_rem  [TASK_SLOTS];
  logic [31:0]   mem_last [TASK_SLOTS];
  logic [7:0]    mem_prio [TASK_SLOTS];
  logic [31:0]   rd_rem_q, rd_last_q;
  logic [7:0]    rd_prio_q;

  req_t          req_q;
  logic [SW:0]   cnt_q;
  logic          pv_q;
  logic [SW-1:0] pidx_q;
  logic          found_q;
  logic [SW-1:0] best_q;
  logic [31:0]   best_rem_q, best_last_q;
  logic [31:0]   dq_q;
  logic [9:0]    dr_q;
  logic [4:0]    dcnt_q;
  logic          sw_q;
  logic [5:0]    created_q;
  status_e       status_q;
  out_t          out_q;
  logic          out_valid_q;

  logic [SW-1:0] rd_addr, wr_addr, tgt, cidx, idle_idx;
  logic          we_rem, we_last, we_prio;
  logic [31:0]   wd_rem, wd_last;
  logic [7:0]    wd_prio;
  logic          tgt_ok, cur_ok, idle_ok, cnt_live, cand, better, wake_hit, scan_end;
  logic [9:0]    divisor;
  logic [10:0]   div_r2;
  logic [31:0]   sleep_t;

  assign tgt      = SW'(req_q.slot);
  assign cidx     = cnt_q[SW-1:0];
  assign idle_idx = SW'(cfg_i.idle_slot);
  assign tgt_ok   = req_q.slot_in_range && used_q[tgt];
  assign cur_ok   = used_q[run_q];
  assign idle_ok  = (32'(cfg_i.idle_slot) < TASK_SLOTS) && used_q[idle_idx];
  assign cnt_live = (cnt_q < N_CNT);
  assign scan_end = !pv_q && !cnt_live;
  assign divisor  = (cfg_i.ms_per_tick == 10'd0) ? 10'd1 : cfg_i.ms_per_tick;
  assign div_r2   = {dr_q, dq_q[31]};
  assign sleep_t  = (dq_q == 32'd0) ? 32'd1 : dq_q;

  // candidate tests on the slot whose memory data just came back
  assign cand     = used_q[pidx_q] && (pidx_q != run_q) && (st_q[pidx_q] == ST_READY);
  assign better   = !found_q || (best_rem_q < rd_rem_q) || (best_last_q > rd_last_q);
  assign wake_hit = used_q[pidx_q] && (st_q[pidx_q] == ST_SLEEPING) && (rd_rem_q <= req_q.now);

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    rd_addr = run_q;
    wr_addr = run_q;
    we_rem  = 1'b0;
    we_last = 1'b0;
    we_prio = 1'b0;
    wd_rem  = 32'd0;
    wd_last = 32'd0;
    wd_prio = req_q.value[7:0];
    case (state_q)
      S_CREATE: begin
        wr_addr = cidx;
        wd_rem  = 32'(req_q.value[7:0]);
        if (cnt_live && !used_q[cidx]) begin
          we_rem  = 1'b1;
          we_last = 1'b1;
          we_prio = 1'b1;
        end
      end
      S_TICK: begin
        we_last = 1'b1;
        wd_last = req_q.now;
        we_rem  = 1'b1;
        wd_rem  = (rd_rem_q > 32'd1) ? rd_rem_q - 32'd1 : 32'(rd_prio_q);
      end
      S_SLEEP: begin
        we_rem = 1'b1;
        wd_rem = req_q.now + sleep_t;
      end
      S_RESCHED: begin
        rd_addr = cnt_live ? cidx : '0;
      end
      S_WAKE: begin
        rd_addr = cnt_live ? cidx : '0;
        wr_addr = pidx_q;
        wd_rem  = 32'd1;
        we_rem  = pv_q && wake_hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_rem) mem_rem[wr_addr] <= wd_rem;
    if (we_last) mem_last[wr_addr] <= wd_last;
    if (we_prio) mem_prio[wr_addr] <= wd_prio;
    rd_rem_q  <= mem_rem[rd_addr];
    rd_last_q <= mem_last[rd_addr];
    rd_prio_q <= mem_prio[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        used_q[i] <= 1'b0;
        st_q[i]   <= ST_FREE;
      end
      run_q       <= '0;
      req_q       <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      pidx_q      <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_rem_q  <= '0;
      best_last_q <= '0;
      dq_q        <= '0;
      dr_q        <= '0;
      dcnt_q      <= '0;
      sw_q        <= 1'b0;
      created_q   <= '0;
      status_q    <= STS_OK;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            req_q     <= q_req_i;
            sw_q      <= 1'b0;
            created_q <= '0;
            status_q  <= STS_OK;
            state_q   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          cnt_q   <= '0;
          pv_q    <= 1'b0;
          found_q <= 1'b0;
          case (req_q.op)
            FN_CREATE: state_q <= S_CREATE;
            FN_TICK: begin
              if (!cur_ok) begin
                status_q <= STS_BAD_SLOT;
                state_q  <= S_DONE;
              end else begin
                state_q <= S_TICK;
              end
            end
            FN_YIELD: state_q <= S_RESCHED;
            FN_BLOCK: begin
              if (!tgt_ok) begin
                status_q <= STS_BAD_SLOT;
                state_q  <= S_DONE;
              end else begin
                st_q[tgt] <= req_q.value_zero ? ST_BLOCKED : ST_WAITING;
                state_q   <= (tgt == run_q) ? S_RESCHED : S_DONE;
              end
            end
            FN_UNBLOCK: begin
              if (!tgt_ok) begin
                status_q <= STS_BAD_SLOT;
              end else if (st_q[tgt] == ST_BLOCKED || st_q[tgt] == ST_WAITING ||
                           st_q[tgt] == ST_SLEEPING) begin
                st_q[tgt] <= ST_READY;
              end
              state_q <= S_DONE;
            end
            FN_SLEEP: begin
              if (!cur_ok) begin
                status_q <= STS_BAD_SLOT;
                state_q  <= S_DONE;
              end else begin
                dq_q    <= req_q.value;
                dr_q    <= '0;
                dcnt_q  <= '0;
                state_q <= S_DIV;
              end
            end
            FN_WAKEUP: state_q <= S_WAKE;
            FN_RELEASE: begin
              if (!tgt_ok || tgt == run_q) begin
                status_q <= STS_BAD_SLOT;
              end else begin
                used_q[tgt] <= 1'b0;
                st_q[tgt]   <= ST_FREE;
              end
              state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_CREATE: begin
          if (!cnt_live) begin
            status_q <= STS_FULL;
            state_q  <= S_DONE;
          end else if (!used_q[cidx]) begin
            used_q[cidx] <= 1'b1;
            st_q[cidx]   <= ST_READY;
            created_q    <= 6'(cidx);
            state_q      <= S_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_TICK: begin
          state_q <= (rd_rem_q > 32'd1) ? S_DONE : S_RESCHED;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (div_r2 >= {1'b0, divisor}) begin
            dr_q <= 10'(div_r2 - {1'b0, divisor});
            dq_q <= {dq_q[30:0], 1'b1};
          end else begin
            dr_q <= div_r2[9:0];
            dq_q <= {dq_q[30:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd31) state_q <= S_SLEEP;
        end
        S_SLEEP: begin
          st_q[run_q] <= ST_SLEEPING;
          state_q     <= S_RESCHED;
        end
        S_RESCHED: begin
          pv_q   <= cnt_live;
          pidx_q <= cidx;
          if (cnt_live) cnt_q <= cnt_q + 1'b1;
          if (pv_q && cand && better) begin
            found_q     <= 1'b1;
            best_q      <= pidx_q;
            best_rem_q  <= rd_rem_q;
            best_last_q <= rd_last_q;
          end
          if (scan_end) begin
            state_q <= S_DONE;
            if (found_q || idle_ok) begin
              if (cur_ok && st_q[run_q] == ST_RUNNING &&
                  (found_q ? best_q : idle_idx) != run_q) st_q[run_q] <= ST_READY;
              st_q[found_q ? best_q : idle_idx] <= ST_RUNNING;
              run_q <= found_q ? best_q : idle_idx;
              sw_q  <= 1'b1;
            end else begin
              status_q <= STS_NO_READY;
            end
          end
        end
        S_WAKE: begin
          pv_q   <= cnt_live;
          pidx_q <= cidx;
          if (cnt_live) cnt_q <= cnt_q + 1'b1;
          if (pv_q && wake_hit) st_q[pidx_q] <= ST_READY;
          if (scan_end) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.running  <= 6'(run_q);
            out_q.switched <= sw_q;
            out_q.created  <= created_q;
            out_q.status   <= status_q;
            out_valid_q    <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(run_q) < TASK_SLOTS) else $error("running slot out of range");

  a_switch_target_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && sw_q) |-> (used_q[run_q] && st_q[run_q] == ST_RUNNING))
    else $error("switched to a slot that is not running");

  a_full_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q == STS_FULL) |-> (created_q == 6'd0))
    else $error("full table reported a created slot");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == S_DISPATCH))
    else $error("popped request not dispatched");

endmodule
